// File: hw/rtl/ptbg_pkg.sv
// Shared types and constants for the pin toggle burst generator.
// Holds operation codes, register indexes and the beat structs.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package ptbg_pkg;

    localparam int CFG_IDX_W = 4;

    localparam logic [3:0] OP_TICK         = 4'd0;
    localparam logic [3:0] OP_START        = 4'd1;
    localparam logic [3:0] OP_COUNTED      = 4'd2;
    localparam logic [3:0] OP_DELAYED      = 4'd3;
    localparam logic [3:0] OP_RESTART      = 4'd4;
    localparam logic [3:0] OP_FORCE        = 4'd5;
    localparam logic [3:0] OP_RESUME       = 4'd6;
    localparam logic [3:0] OP_SET_LOW      = 4'd7;
    localparam logic [3:0] OP_SET_HIGH     = 4'd8;
    localparam logic [3:0] OP_BURST_START  = 4'd9;
    localparam logic [3:0] OP_BURST_STOP   = 4'd10;

    localparam logic [CFG_IDX_W-1:0] CFG_LOW_PERIOD   = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HIGH_PERIOD  = 4'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_START_LEVEL  = 4'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_EDGE_COUNT   = 4'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_WAIT_PERIOD  = 4'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_BURST_ON     = 4'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_BURST_OFF    = 4'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_REST_LEVEL   = 4'd7;

    typedef struct packed {
        logic [31:0] low_period;
        logic [31:0] high_period;
        logic        start_level;
        logic [15:0] edge_count;
        logic [31:0] wait_period;
        logic [31:0] burst_on_period;
        logic [31:0] burst_off_period;
        logic        rest_level;
    } t_cfg;

    localparam t_cfg CFG_RESET = '{
        low_period:       32'd500,
        high_period:      32'd500,
        start_level:      1'b0,
        edge_count:       16'd0,
        wait_period:      32'd0,
        burst_on_period:  32'd0,
        burst_off_period: 32'd0,
        rest_level:       1'b0
    };

    typedef struct packed {
        logic [3:0]  operation;
        logic        level;
        logic [31:0] new_period;
    } t_item;

    typedef struct packed {
        logic        pin_level;
        logic        is_toggling;
        logic        is_waiting;
        logic        is_bursting;
        logic [15:0] remaining_edges;
        logic        edge_counted;
    } t_result;

endpackage

`default_nettype wire

// File: hw/rtl/ptbg_cfg.sv
// Configuration register file for the pin toggle burst generator.
// Depends on ptbg_pkg for register indexes and the t_cfg struct.
`timescale 1ns / 1ps
`default_nettype none

module ptbg_cfg
    import ptbg_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_cfg_valid,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [31:0]          i_cfg_data,
    output      logic                 o_cfg_ready,
    output      t_cfg                 o_cfg
);

    t_cfg r_cfg;

    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= CFG_RESET;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_LOW_PERIOD:  r_cfg.low_period       <= i_cfg_data;
                CFG_HIGH_PERIOD: r_cfg.high_period      <= i_cfg_data;
                CFG_START_LEVEL: r_cfg.start_level      <= i_cfg_data[0];
                CFG_EDGE_COUNT:  r_cfg.edge_count       <= i_cfg_data[15:0];
                CFG_WAIT_PERIOD: r_cfg.wait_period      <= i_cfg_data;
                CFG_BURST_ON:    r_cfg.burst_on_period  <= i_cfg_data;
                CFG_BURST_OFF:   r_cfg.burst_off_period <= i_cfg_data;
                CFG_REST_LEVEL:  r_cfg.rest_level       <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/ptbg_core.sv
// Generator state and the single-pass update for one tick or command beat.
// Depends on ptbg_pkg for operation codes and the beat structs.
`timescale 1ns / 1ps
`default_nettype none

module ptbg_core
    import ptbg_pkg::*;
#(
    parameter int PERIOD_BITS = 32,
    parameter int COUNT_BITS  = 16
) (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_step,
    input  wire t_item   i_item,
    input  wire t_cfg    i_cfg,
    output      t_result o_result
);

    localparam int PB = PERIOD_BITS;
    localparam int EB = (COUNT_BITS < 16) ? COUNT_BITS : 16;

    logic          r_out_level, r_phase_high, r_toggling, r_counting, r_waiting;
    logic          r_bursting, r_ever_started, r_burst_phase_on, r_first_counted;
    logic [PB-1:0] r_edge_timer, r_wait_timer, r_burst_timer;
    logic [PB-1:0] r_active_low, r_active_high;
    logic [EB-1:0] r_edges_left;

    logic          n_out_level, n_phase_high, n_toggling, n_counting, n_waiting;
    logic          n_bursting, n_ever_started, n_burst_phase_on, n_first_counted;
    logic [PB-1:0] n_edge_timer, n_wait_timer, n_burst_timer;
    logic [PB-1:0] n_active_low, n_active_high;
    logic [EB-1:0] n_edges_left;

    logic          do_begin, begin_counted, begin_load, counted_edge;
    logic [PB-1:0] edge_per, burst_per;

    function automatic logic [PB-1:0] bump(input logic [PB-1:0] t);
        return (&t) ? t : t + 1'b1;
    endfunction

    always_comb begin
        n_out_level      = r_out_level;
        n_phase_high     = r_phase_high;
        n_toggling       = r_toggling;
        n_counting       = r_counting;
        n_waiting        = r_waiting;
        n_bursting       = r_bursting;
        n_ever_started   = r_ever_started;
        n_burst_phase_on = r_burst_phase_on;
        n_first_counted  = r_first_counted;
        n_edge_timer     = r_edge_timer;
        n_wait_timer     = r_wait_timer;
        n_burst_timer    = r_burst_timer;
        n_active_low     = r_active_low;
        n_active_high    = r_active_high;
        n_edges_left     = r_edges_left;
        do_begin         = 1'b0;
        begin_counted    = 1'b0;
        begin_load       = 1'b0;
        counted_edge     = 1'b0;
        edge_per         = r_phase_high ? r_active_high : r_active_low;
        burst_per        = r_burst_phase_on ? i_cfg.burst_on_period[PB-1:0]
                                            : i_cfg.burst_off_period[PB-1:0];

        case (i_item.operation)
            OP_TICK: begin
                if (r_toggling) begin
                    n_edge_timer = bump(r_edge_timer);
                    if (n_edge_timer >= edge_per) begin
                        n_out_level  = !r_out_level;
                        n_phase_high = !r_phase_high;
                        n_edge_timer = '0;
                        if (r_counting) begin
                            counted_edge = 1'b1;
                            if (r_edges_left != '0) begin
                                n_edges_left = r_edges_left - 1'b1;
                            end
                            if (n_edges_left == '0) begin
                                n_toggling = 1'b0;
                            end
                        end
                    end
                end
                if (r_waiting) begin
                    n_wait_timer = bump(r_wait_timer);
                    if (n_wait_timer >= i_cfg.wait_period[PB-1:0]) begin
                        do_begin = 1'b1;
                    end
                end
            end
            OP_START: begin
                do_begin   = 1'b1;
                begin_load = 1'b1;
            end
            OP_COUNTED: begin
                do_begin      = 1'b1;
                begin_load    = 1'b1;
                begin_counted = 1'b1;
            end
            OP_DELAYED: begin
                n_active_low  = i_cfg.low_period[PB-1:0];
                n_active_high = i_cfg.high_period[PB-1:0];
                n_out_level   = i_cfg.start_level;
                n_phase_high  = i_cfg.start_level;
                n_toggling    = 1'b0;
                n_waiting     = 1'b1;
                n_wait_timer  = '0;
            end
            OP_RESTART: begin
                do_begin      = r_ever_started;
                begin_counted = r_first_counted;
            end
            OP_FORCE: begin
                n_out_level = i_item.level;
                n_toggling  = 1'b0;
            end
            OP_RESUME: begin
                if (r_ever_started) begin
                    n_toggling = 1'b1;
                end
            end
            OP_SET_LOW: begin
                if (r_toggling) begin
                    n_active_low = i_item.new_period[PB-1:0];
                end
            end
            OP_SET_HIGH: begin
                if (r_toggling) begin
                    n_active_high = i_item.new_period[PB-1:0];
                end
            end
            OP_BURST_START: begin
                n_active_low     = i_cfg.low_period[PB-1:0];
                n_active_high    = i_cfg.high_period[PB-1:0];
                n_bursting       = 1'b1;
                n_burst_phase_on = 1'b1;
                n_burst_timer    = '0;
                n_toggling       = 1'b1;
                n_out_level      = i_cfg.rest_level;
                n_phase_high     = i_cfg.rest_level;
                n_edge_timer     = '0;
            end
            OP_BURST_STOP: begin
                n_bursting  = 1'b0;
                n_toggling  = 1'b0;
                n_out_level = i_item.level;
            end
            default: begin
            end
        endcase

        if (do_begin) begin
            if (begin_load) begin
                n_active_low  = i_cfg.low_period[PB-1:0];
                n_active_high = i_cfg.high_period[PB-1:0];
            end
            n_out_level     = i_cfg.start_level;
            n_phase_high    = i_cfg.start_level;
            n_edge_timer    = '0;
            n_toggling      = 1'b1;
            n_ever_started  = 1'b1;
            n_waiting       = 1'b0;
            n_counting      = begin_counted;
            n_first_counted = begin_counted;
            if (begin_counted) begin
                n_edges_left = i_cfg.edge_count[EB-1:0];
            end
        end

        if (i_item.operation == OP_TICK && r_bursting) begin
            n_burst_timer = bump(r_burst_timer);
            if (n_burst_timer >= burst_per) begin
                n_burst_phase_on = !r_burst_phase_on;
                n_burst_timer    = '0;
                n_toggling       = !r_burst_phase_on;
                if (!r_burst_phase_on) begin
                    n_edge_timer = '0;
                    n_phase_high = n_out_level;
                end else begin
                    n_out_level  = i_cfg.rest_level;
                    n_phase_high = i_cfg.rest_level;
                end
            end
        end
    end

    assign o_result = '{
        pin_level:       n_out_level,
        is_toggling:     n_toggling,
        is_waiting:      n_waiting,
        is_bursting:     n_bursting,
        remaining_edges: 16'(n_edges_left),
        edge_counted:    counted_edge
    };

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_level      <= 1'b0;
            r_phase_high     <= 1'b0;
            r_toggling       <= 1'b0;
            r_counting       <= 1'b0;
            r_waiting        <= 1'b0;
            r_bursting       <= 1'b0;
            r_ever_started   <= 1'b0;
            r_burst_phase_on <= 1'b0;
            r_first_counted  <= 1'b0;
            r_edge_timer     <= '0;
            r_wait_timer     <= '0;
            r_burst_timer    <= '0;
            r_active_low     <= '0;
            r_active_high    <= '0;
            r_edges_left     <= '0;
        end else if (i_step) begin
            r_out_level      <= n_out_level;
            r_phase_high     <= n_phase_high;
            r_toggling       <= n_toggling;
            r_counting       <= n_counting;
            r_waiting        <= n_waiting;
            r_bursting       <= n_bursting;
            r_ever_started   <= n_ever_started;
            r_burst_phase_on <= n_burst_phase_on;
            r_first_counted  <= n_first_counted;
            r_edge_timer     <= n_edge_timer;
            r_wait_timer     <= n_wait_timer;
            r_burst_timer    <= n_burst_timer;
            r_active_low     <= n_active_low;
            r_active_high    <= n_active_high;
            r_edges_left     <= n_edges_left;
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/pin_toggle_burst_generator.sv
// A beat is held in the input register, loaded on accept, then in the result
// register, loaded when the core steps. Throughput: one beat per cycle while
// the output is not stalled; the single-pass state update sets the rate.
// Reset (synchronous, active low) clears all generator state and valid flags
// and loads the register defaults.
// Top level; depends on ptbg_pkg, ptbg_cfg and ptbg_core.
`timescale 1ns / 1ps
`default_nettype none

module pin_toggle_burst_generator
    import ptbg_pkg::*;
#(
    parameter int PERIOD_BITS = 32,
    parameter int COUNT_BITS  = 16
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,

    input  wire logic                 i_in_valid,
    output      logic                 o_in_stall,
    input  wire logic [3:0]           i_operation,
    input  wire logic                 i_level,
    input  wire logic [31:0]          i_new_period,

    output      logic                 o_out_valid,
    input  wire logic                 i_out_stall,
    output      logic                 o_pin_level,
    output      logic                 o_is_toggling,
    output      logic                 o_is_waiting,
    output      logic                 o_is_bursting,
    output      logic [15:0]          o_remaining_edges,
    output      logic                 o_edge_counted,

    input  wire logic                 i_cfg_valid,
    output      logic                 o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [31:0]          i_cfg_data
);

    t_cfg    cfg;
    t_item   r_item;
    t_result result;
    t_result r_result;
    logic    r_in_valid;
    logic    r_out_valid;
    logic    advance;

    assign advance    = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !advance;

    ptbg_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg_ready (o_cfg_ready),
        .o_cfg       (cfg)
    );

    ptbg_core #(
        .PERIOD_BITS (PERIOD_BITS),
        .COUNT_BITS  (COUNT_BITS)
    ) u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (advance),
        .i_item   (r_item),
        .i_cfg    (cfg),
        .o_result (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_item <= '{operation: i_operation, level: i_level, new_period: i_new_period};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_result <= result;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_pin_level       = r_result.pin_level;
    assign o_is_toggling     = r_result.is_toggling;
    assign o_is_waiting      = r_result.is_waiting;
    assign o_is_bursting     = r_result.is_bursting;
    assign o_remaining_edges = r_result.remaining_edges;
    assign o_edge_counted    = r_result.edge_counted;

endmodule

`default_nettype wire

// File: test/tb_pin_toggle_burst_generator.sv
// Self-checking testbench for pin_toggle_burst_generator: a directed table, then
// random ticks and commands over several register settings, checked beat by beat.
// Depends on ptbg_pkg and the generator RTL.
`timescale 1ns / 1ps

module tb_pin_toggle_burst_generator;
    import ptbg_pkg::*;

    localparam int PERIOD_BITS = 32;
    localparam int COUNT_BITS = 16;
    localparam logic [31:0] PMAX = 32'((64'd1 << PERIOD_BITS) - 64'd1);
    localparam logic [15:0] CMAX = 16'((64'd1 << COUNT_BITS) - 64'd1);

    localparam logic [3:0] OP_SPARE_LO = 4'd11;
    localparam logic [3:0] OP_SPARE_HI = 4'd15;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 4'd12;

    localparam int N_PHASES = 8;
    localparam int PHASE_ITEMS = 150;
    localparam int HOLD_CYCLES = 200;
    localparam int DRAIN_CYCLES = 6;
    localparam int CYCLE_LIMIT = 400000;
    localparam int PRINT_CAP = 50;

    localparam t_result IDLE_LOW = '0;
    localparam t_result FORCED_HIGH = '{1'b1, 1'b0, 1'b0, 1'b0, 16'd0, 1'b0};

    typedef struct packed {
        t_item   it;
        logic    typed;
        t_result want;
    } dir_row_t;

    localparam int DIR_N = 27;
    localparam dir_row_t DIR_ROWS [DIR_N] = '{
        '{'{OP_TICK,        1'b0, 32'd0},        1'b1, IDLE_LOW},
        '{'{OP_RESTART,     1'b0, 32'd0},        1'b1, IDLE_LOW},
        '{'{OP_RESUME,      1'b1, 32'd0},        1'b1, IDLE_LOW},
        '{'{OP_SET_LOW,     1'b1, 32'hFFFFFFFF}, 1'b1, IDLE_LOW},
        '{'{OP_SET_HIGH,    1'b0, 32'd0},        1'b1, IDLE_LOW},
        '{'{OP_FORCE,       1'b1, 32'd0},        1'b1, FORCED_HIGH},
        '{'{OP_SPARE_HI,    1'b0, 32'hFFFFFFFF}, 1'b1, FORCED_HIGH},
        '{'{OP_SPARE_LO,    1'b0, 32'd0},        1'b1, FORCED_HIGH},
        '{'{OP_FORCE,       1'b0, 32'hFFFFFFFF}, 1'b1, IDLE_LOW},
        '{'{OP_COUNTED,     1'b0, 32'd0},        1'b0, IDLE_LOW},
        '{'{OP_SET_LOW,     1'b0, 32'd0},        1'b0, IDLE_LOW},
        '{'{OP_TICK,        1'b0, 32'd0},        1'b0, IDLE_LOW},
        '{'{OP_RESTART,     1'b0, 32'd0},        1'b0, IDLE_LOW},
        '{'{OP_TICK,        1'b0, 32'd0},        1'b0, IDLE_LOW},
        '{'{OP_START,       1'b0, 32'd0},        1'b0, IDLE_LOW},
        '{'{OP_SET_HIGH,    1'b0, 32'd1},        1'b0, IDLE_LOW},
        '{'{OP_SET_LOW,     1'b0, 32'd1},        1'b0, IDLE_LOW},
        '{'{OP_TICK,        1'b0, 32'd0},        1'b0, IDLE_LOW},
        '{'{OP_TICK,        1'b0, 32'd0},        1'b0, IDLE_LOW},
        '{'{OP_RESTART,     1'b0, 32'd0},        1'b0, IDLE_LOW},
        '{'{OP_DELAYED,     1'b0, 32'd0},        1'b0, IDLE_LOW},
        '{'{OP_TICK,        1'b0, 32'd0},        1'b0, IDLE_LOW},
        '{'{OP_BURST_START, 1'b0, 32'd0},        1'b0, IDLE_LOW},
        '{'{OP_TICK,        1'b0, 32'd0},        1'b0, IDLE_LOW},
        '{'{OP_TICK,        1'b0, 32'd0},        1'b0, IDLE_LOW},
        '{'{OP_RESUME,      1'b0, 32'd0},        1'b0, IDLE_LOW},
        '{'{OP_BURST_STOP,  1'b1, 32'd0},        1'b1, FORCED_HIGH}
    };

    typedef struct {
        logic        out_level;
        logic        phase_high;
        logic        toggling_on;
        logic        counting_on;
        logic        waiting_on;
        logic        bursting_on;
        logic        ever_started;
        logic        burst_phase_on;
        logic        last_counted;
        logic [31:0] edge_timer;
        logic [31:0] wait_timer;
        logic [31:0] burst_timer;
        logic [31:0] act_low;
        logic [31:0] act_high;
        logic [15:0] edges_left;
    } gen_state_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 in_valid = 1'b0;
    logic                 in_stall;
    logic [3:0]           operation = OP_TICK;
    logic                 level = 1'b0;
    logic [31:0]          new_period = '0;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    logic                 pin_level;
    logic                 is_toggling;
    logic                 is_waiting;
    logic                 is_bursting;
    logic [15:0]          remaining_edges;
    logic                 edge_counted;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = CFG_LOW_PERIOD;
    logic [31:0]          cfg_data = '0;

    gen_state_t gen;
    t_cfg       regs;
    t_result    pending_levels[$];
    t_result    got_beat;
    t_result    want_beat;

    int  errors = 0;
    int  n_items = 0;
    int  n_checked = 0;
    int  n_counted = 0;
    int  n_burst = 0;
    int  n_settings = 0;
    int  cycles = 0;
    bit  src_quiet = 1'b0;
    bit  sink_quiet = 1'b0;
    int  hold_reqs = 0;
    int  hold_seen = 0;
    int  hold_left = 0;
    int  run_left = 0;

    pin_toggle_burst_generator #(
        .PERIOD_BITS(PERIOD_BITS),
        .COUNT_BITS(COUNT_BITS)
    ) i_dut (
        .i_clk(clk),
        .i_rst_n(rst_n),
        .i_in_valid(in_valid),
        .o_in_stall(in_stall),
        .i_operation(operation),
        .i_level(level),
        .i_new_period(new_period),
        .o_out_valid(out_valid),
        .i_out_stall(out_stall),
        .o_pin_level(pin_level),
        .o_is_toggling(is_toggling),
        .o_is_waiting(is_waiting),
        .o_is_bursting(is_bursting),
        .o_remaining_edges(remaining_edges),
        .o_edge_counted(edge_counted),
        .i_cfg_valid(cfg_valid),
        .o_cfg_ready(cfg_ready),
        .i_cfg_index(cfg_index),
        .i_cfg_data(cfg_data)
    );

    initial begin
        forever #2 clk = ~clk;
    end

    function automatic logic [31:0] sat_inc(logic [31:0] t);
        return (t >= PMAX) ? PMAX : t + 32'd1;
    endfunction

    function automatic void launch_toggle(logic counted, logic load);
        if (load) begin
            gen.act_low = regs.low_period & PMAX;
            gen.act_high = regs.high_period & PMAX;
        end
        gen.out_level = regs.start_level;
        gen.phase_high = gen.out_level;
        gen.edge_timer = '0;
        gen.toggling_on = 1'b1;
        gen.ever_started = 1'b1;
        gen.waiting_on = 1'b0;
        gen.counting_on = counted;
        gen.last_counted = counted;
        if (counted)
            gen.edges_left = regs.edge_count & CMAX;
    endfunction

    function automatic t_result step_generator(t_item it);
        logic [31:0] per;
        logic [31:0] np;
        logic        counted;
        t_result     r;
        np = it.new_period & PMAX;
        counted = 1'b0;
        case (it.operation)
            OP_TICK: begin
                if (gen.toggling_on) begin
                    per = gen.phase_high ? gen.act_high : gen.act_low;
                    gen.edge_timer = sat_inc(gen.edge_timer);
                    if (gen.edge_timer >= per) begin
                        gen.out_level = !gen.out_level;
                        gen.phase_high = !gen.phase_high;
                        gen.edge_timer = '0;
                        if (gen.counting_on) begin
                            counted = 1'b1;
                            if (gen.edges_left != 16'd0)
                                gen.edges_left = gen.edges_left - 16'd1;
                            if (gen.edges_left == 16'd0)
                                gen.toggling_on = 1'b0;
                        end
                    end
                end
                if (gen.waiting_on) begin
                    gen.wait_timer = sat_inc(gen.wait_timer);
                    if (gen.wait_timer >= (regs.wait_period & PMAX))
                        launch_toggle(1'b0, 1'b0);
                end
                if (gen.bursting_on) begin
                    per = (gen.burst_phase_on ? regs.burst_on_period
                                              : regs.burst_off_period) & PMAX;
                    gen.burst_timer = sat_inc(gen.burst_timer);
                    if (gen.burst_timer >= per) begin
                        gen.burst_phase_on = !gen.burst_phase_on;
                        gen.burst_timer = '0;
                        gen.toggling_on = gen.burst_phase_on;
                        if (gen.burst_phase_on) begin
                            gen.edge_timer = '0;
                            gen.phase_high = gen.out_level;
                        end else begin
                            gen.out_level = regs.rest_level;
                            gen.phase_high = gen.out_level;
                        end
                    end
                end
            end
            OP_START: launch_toggle(1'b0, 1'b1);
            OP_COUNTED: launch_toggle(1'b1, 1'b1);
            OP_DELAYED: begin
                gen.act_low = regs.low_period & PMAX;
                gen.act_high = regs.high_period & PMAX;
                gen.out_level = regs.start_level;
                gen.phase_high = gen.out_level;
                gen.toggling_on = 1'b0;
                gen.waiting_on = 1'b1;
                gen.wait_timer = '0;
            end
            OP_RESTART: begin
                if (gen.ever_started)
                    launch_toggle(gen.last_counted, 1'b0);
            end
            OP_FORCE: begin
                gen.out_level = it.level;
                gen.toggling_on = 1'b0;
            end
            OP_RESUME: begin
                if (gen.ever_started)
                    gen.toggling_on = 1'b1;
            end
            OP_SET_LOW: begin
                if (gen.toggling_on)
                    gen.act_low = np;
            end
            OP_SET_HIGH: begin
                if (gen.toggling_on)
                    gen.act_high = np;
            end
            OP_BURST_START: begin
                gen.act_low = regs.low_period & PMAX;
                gen.act_high = regs.high_period & PMAX;
                gen.bursting_on = 1'b1;
                gen.burst_phase_on = 1'b1;
                gen.burst_timer = '0;
                gen.toggling_on = 1'b1;
                gen.out_level = regs.rest_level;
                gen.phase_high = gen.out_level;
                gen.edge_timer = '0;
            end
            OP_BURST_STOP: begin
                gen.bursting_on = 1'b0;
                gen.toggling_on = 1'b0;
                gen.out_level = it.level;
            end
            default: ;
        endcase
        r.pin_level = gen.out_level;
        r.is_toggling = gen.toggling_on;
        r.is_waiting = gen.waiting_on;
        r.is_bursting = gen.bursting_on;
        r.remaining_edges = gen.edges_left;
        r.edge_counted = counted;
        return r;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(99, 0);
        if (src_quiet || r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(3, 1);
        return $urandom_range(30, 6);
    endfunction

    function automatic t_item random_item();
        int    r;
        t_item it;
        r = $urandom_range(99, 0);
        if (r < 55)
            it.operation = OP_TICK;
        else if (r < 97)
            it.operation = 4'($urandom_range(OP_BURST_STOP, OP_START));
        else
            it.operation = 4'($urandom_range(OP_SPARE_HI, OP_SPARE_LO));
        it.level = 1'($urandom_range(1, 0));
        r = $urandom_range(99, 0);
        if (r < 70)
            it.new_period = $urandom_range(6, 0);
        else if (r < 85)
            it.new_period = $urandom;
        else if (r < 92)
            it.new_period = PMAX;
        else
            it.new_period = '0;
        return it;
    endfunction

    task automatic report_mismatch(string msg);
        errors++;
        if (errors <= PRINT_CAP)
            $display("mismatch at %0t, beat %0d: %s", $realtime, n_checked, msg);
    endtask

    task automatic check_fields(t_result got, t_result want);
        if (got.pin_level !== want.pin_level)
            report_mismatch($sformatf("pin_level %0b want %0b", got.pin_level,
                                      want.pin_level));
        if (got.is_toggling !== want.is_toggling)
            report_mismatch($sformatf("is_toggling %0b want %0b", got.is_toggling,
                                      want.is_toggling));
        if (got.is_waiting !== want.is_waiting)
            report_mismatch($sformatf("is_waiting %0b want %0b", got.is_waiting,
                                      want.is_waiting));
        if (got.is_bursting !== want.is_bursting)
            report_mismatch($sformatf("is_bursting %0b want %0b", got.is_bursting,
                                      want.is_bursting));
        if (got.remaining_edges !== want.remaining_edges)
            report_mismatch($sformatf("remaining_edges %0d want %0d",
                                      got.remaining_edges, want.remaining_edges));
        if (got.edge_counted !== want.edge_counted)
            report_mismatch($sformatf("edge_counted %0b want %0b", got.edge_counted,
                                      want.edge_counted));
    endtask

    task automatic send_item(t_item it, logic typed, t_result want);
        int      gap;
        t_result pred;
        gap = pick_gap();
        if (gap != 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        operation <= it.operation;
        level <= it.level;
        new_period <= it.new_period;
        do @(posedge clk); while (!(in_valid && !in_stall));
        pred = step_generator(it);
        pending_levels.push_back(typed ? want : pred);
        n_items++;
    endtask

    task automatic put_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do @(posedge clk); while (!(cfg_valid && cfg_ready));
        case (idx)
            CFG_LOW_PERIOD:  regs.low_period = data;
            CFG_HIGH_PERIOD: regs.high_period = data;
            CFG_START_LEVEL: regs.start_level = data[0];
            CFG_EDGE_COUNT:  regs.edge_count = data[15:0];
            CFG_WAIT_PERIOD: regs.wait_period = data;
            CFG_BURST_ON:    regs.burst_on_period = data;
            CFG_BURST_OFF:   regs.burst_off_period = data;
            CFG_REST_LEVEL:  regs.rest_level = data[0];
            default: ;
        endcase
    endtask

    task automatic load_regs(t_cfg c, bit junk);
        logic [31:0] hi;
        hi = junk ? $urandom : 32'd0;
        put_reg(CFG_LOW_PERIOD, c.low_period);
        put_reg(CFG_HIGH_PERIOD, c.high_period);
        put_reg(CFG_START_LEVEL, {hi[31:1], c.start_level});
        put_reg(CFG_EDGE_COUNT, {hi[31:16], c.edge_count});
        put_reg(CFG_WAIT_PERIOD, c.wait_period);
        put_reg(CFG_BURST_ON, c.burst_on_period);
        put_reg(CFG_BURST_OFF, c.burst_off_period);
        put_reg(CFG_REST_LEVEL, {hi[31:1], c.rest_level});
        if (junk)
            put_reg(CFG_SPARE, $urandom);
        cfg_valid <= 1'b0;
        n_settings++;
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        while (pending_levels.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    always @(posedge clk) begin
        if (hold_left != 0) begin
            out_stall <= 1'b1;
            hold_left <= hold_left - 1;
        end else if (hold_reqs != hold_seen) begin
            hold_seen <= hold_reqs;
            hold_left <= HOLD_CYCLES - 1;
            out_stall <= 1'b1;
        end else if (run_left != 0) begin
            run_left <= run_left - 1;
        end else begin
            int r;
            r = $urandom_range(99, 0);
            if (sink_quiet || r < 55) begin
                out_stall <= 1'b0;
                run_left <= $urandom_range(6, 0);
            end else if (r < 90) begin
                out_stall <= 1'b1;
                run_left <= $urandom_range(2, 0);
            end else begin
                out_stall <= 1'b1;
                run_left <= $urandom_range(40, 8);
            end
        end
    end

    always @(posedge clk) begin
        if (rst_n && out_valid && !out_stall) begin
            got_beat = '{pin_level, is_toggling, is_waiting, is_bursting,
                         remaining_edges, edge_counted};
            if (pending_levels.size() == 0) begin
                report_mismatch("result beat with nothing pending");
            end else begin
                want_beat = pending_levels.pop_front();
                check_fields(got_beat, want_beat);
                n_checked++;
                if (got_beat.edge_counted)
                    n_counted++;
                if (got_beat.is_bursting)
                    n_burst++;
            end
        end
    end

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("FAIL pin_toggle_burst_generator");
            $finish;
        end
    end

    initial begin
        t_cfg c;
        gen = '{default: '0};
        regs = CFG_RESET;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < DIR_N; i++)
            send_item(DIR_ROWS[i].it, DIR_ROWS[i].typed, DIR_ROWS[i].want);
        drain_results();

        for (int ph = 0; ph < N_PHASES; ph++) begin
            if (ph == 0) begin
                c = '0;
            end else if (ph == 1) begin
                c = '{PMAX, PMAX, 1'b1, CMAX, PMAX, PMAX, PMAX, 1'b1};
            end else begin
                c.low_period = $urandom_range(5, 0);
                c.high_period = $urandom_range(5, 0);
                c.start_level = 1'($urandom_range(1, 0));
                c.edge_count = ($urandom_range(3, 0) == 0) ? 16'($urandom)
                                                           : 16'($urandom_range(6, 0));
                c.wait_period = $urandom_range(8, 0);
                c.burst_on_period = $urandom_range(12, 1);
                c.burst_off_period = $urandom_range(8, 0);
                c.rest_level = 1'($urandom_range(1, 0));
            end
            load_regs(c, ph >= 2);
            src_quiet = (ph == 3) || (ph == 5);
            sink_quiet <= (ph == 3);
            if (ph == 5)
                hold_reqs <= hold_reqs + 1;
            repeat (PHASE_ITEMS) send_item(random_item(), 1'b0, IDLE_LOW);
            drain_results();
        end

        $display("drove %0d beats across %0d register settings; checked %0d result beats",
                 n_items, n_settings, n_checked);
        $display("saw %0d counted edges and %0d beats in burst mode", n_counted, n_burst);
        if (errors == 0)
            $display("PASS pin_toggle_burst_generator");
        else
            $display("FAIL pin_toggle_burst_generator");
        $finish;
    end

endmodule
